@@ sv/tiqr_pkg.sv @@
// tiqr_pkg: shared types and constants for the task id queue
// command codes, field widths and the control bundle sent to every cell
// no dependencies
`timescale 1ns / 1ps

package tiqr_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IN_W    = 24;  // command + task_id, padded to bytes
  localparam int unsigned OUT_W   = 24;  // ok + out_id + count + empty, padded

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic            fire;
    cmd_e            cmd;
    logic [ID_W-1:0] key;
  } cell_ctrl_t;

endpackage

@@ sv/tiqr_cell.sv @@
// tiqr_cell: one slot of the queue, holds a single task id
// compares against the broadcast key, passes the match chain on, shifts from its neighbor
// depends on tiqr_pkg
`timescale 1ns / 1ps

module tiqr_cell
  import tiqr_pkg::*;
(
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic            occupied_i,  // slot lies below the count
  input  logic            tail_i,      // slot is the first free one
  input  logic [ID_W-1:0] next_id_i,   // id of the next slot, one step farther from the head
  input  logic            hit_i,       // a nearer slot already matched
  output logic            hit_o,
  output logic [ID_W-1:0] id_o
);

  logic [ID_W-1:0] id_q, id_d;
  logic            match;

  assign match = occupied_i && (id_q == ctrl_i.key);
  assign hit_o = hit_i || match;
  assign id_o  = id_q;

  always_comb begin
    id_d = id_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.cmd)
        CMD_PUSH: begin
          if (tail_i) id_d = ctrl_i.key;
        end
        CMD_POP: begin
          id_d = next_id_i;
        end
        CMD_REMOVE: begin
          // the matching slot and every slot behind it move toward the head
          if (hit_o) id_d = next_id_i;
        end
        default: begin
          id_d = id_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

@@ sv/task_id_queue_with_removal_core.sv @@
// task_id_queue_with_removal_core: ordered task id queue with find and remove
// a result is registered and appears in the cycle after its command transaction
// throughput: one command per cycle unless a stalled result holds s_axis_tready low, set by the
//   per-cell compare and the match chain that ripples through all DEPTH cells within that cycle
// reset: count and output valid clear at once; cell contents are not cleared
// depends on tiqr_pkg and tiqr_cell
`timescale 1ns / 1ps

module task_id_queue_with_removal_core
  import tiqr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // [1:0] command, [17:2] task_id
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o    // [0] ok, [16:1] out_id, [21:17] count,
                                             // [22] empty_res
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cell_ctrl_t       ctrl;
  logic             fire;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  cell_id [DEPTH];
  logic [ID_W-1:0]  next_id [DEPTH];
  logic [DEPTH:0]   hit_chain;
  logic             any_hit;
  logic             not_empty, not_full;

  logic               out_valid_q;
  logic               ok_q, ok_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic [COUNT_W-1:0] cnt_field_q;
  logic               empty_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  assign ctrl.fire = fire;
  assign ctrl.cmd  = cmd_e'(s_axis_tdata_i[1:0]);
  assign ctrl.key  = s_axis_tdata_i[ID_W+1:2];

  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[DEPTH];
  assign not_empty    = (count_q != '0);
  assign not_full     = (count_q < CNT_W'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign next_id[i] = '0;
    end else begin : g_mid
      assign next_id[i] = cell_id[i+1];
    end

    tiqr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CNT_W'(i) < count_q),
      .tail_i     (CNT_W'(i) == count_q),
      .next_id_i  (next_id[i]),
      .hit_i      (hit_chain[i]),
      .hit_o      (hit_chain[i+1]),
      .id_o       (cell_id[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    ok_d     = 1'b0;
    out_id_d = '0;
    case (ctrl.cmd)
      CMD_PUSH: begin
        ok_d = not_full;
        if (not_full) count_d = count_q + CNT_W'(1);
      end
      CMD_POP: begin
        ok_d = not_empty;
        if (not_empty) begin
          out_id_d = cell_id[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
      CMD_FIND: begin
        ok_d = any_hit;
        if (any_hit) out_id_d = ctrl.key;
      end
      CMD_REMOVE: begin
        ok_d = any_hit;
        if (any_hit) count_d = count_q - CNT_W'(1);
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each command transaction
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ok_q        <= ok_d;
      out_id_q    <= out_id_d;
      cnt_field_q <= COUNT_W'(count_d);
      empty_q     <= (count_d == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, empty_q, cnt_field_q, out_id_q, ok_q};

endmodule

@@ sv/tiqr_checker.sv @@
// tiqr_checker: port-level checks for the task id queue
// watches the top level's stream ports only; bound to the top level below
// depends on tiqr_pkg and task_id_queue_with_removal_core
`timescale 1ns / 1ps

module tiqr_checker
  import tiqr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // every command transaction produces a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("command without result");

  // with no pending result the input side must be open
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output stage");

  // empty flag agrees with the count, which never exceeds the depth
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (DEPTH < 32) |->
      (m_axis_tdata_o[22] == (m_axis_tdata_o[21:17] == 5'd0)) &&
      (32'(m_axis_tdata_o[21:17]) <= DEPTH))
    else $error("count or empty flag inconsistent");

endmodule

bind task_id_queue_with_removal_core tiqr_checker #(.DEPTH(DEPTH)) u_tiqr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ sim/tb_task_id_queue_with_removal_core.sv @@
// tb_task_id_queue_with_removal_core: self-checking bench for the task id queue
// drives push, pop, find and remove commands and predicts every result in a local queue
// depends on tiqr_pkg and task_id_queue_with_removal_core
`timescale 1ns / 1ps

module tb_task_id_queue_with_removal_core;
  import tiqr_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned HOLDOFF_AT  = 800;
  localparam int unsigned HOLDOFF_LEN = 300;
  localparam int unsigned QUIET_START = 1500;
  localparam int unsigned QUIET_STOP  = 2100;
  localparam int unsigned RANDOM_CMDS = 1730;

  typedef struct {
    cmd_e            cmd;
    logic [ID_W-1:0] id;
    bit              wait_drain;  // hold until every outstanding result is back
  } task_cmd_t;

  typedef struct packed {
    logic               ok;
    logic [ID_W-1:0]    out_id;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } queue_result_t;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  task_cmd_t       pending_cmds[$];
  task_cmd_t       offered;
  queue_result_t   expected_results[$];
  logic [ID_W-1:0] queued_ids[$];
  logic [ID_W-1:0] id_pool[8] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE,
                                  16'hA5A5, 16'h5A5A, 16'h00FF, 16'hFF00};

  int unsigned cycle_cnt = 0;
  int unsigned holdoff_left = 0;
  int unsigned fail_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned full_refusals = 0;
  int unsigned peak_count = 0;
  int unsigned cmd_total[4] = '{0, 0, 0, 0};
  int unsigned cmd_ok[4] = '{0, 0, 0, 0};
  logic        quiet_window;

  task_id_queue_with_removal_core #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  assign quiet_window = (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_STOP);

  // applies one command to the local copy of the queue and returns its result
  function automatic queue_result_t predict_queue_result(cmd_e cmd, logic [ID_W-1:0] id);
    queue_result_t res;
    int            hit;
    res = '0;
    hit = -1;
    foreach (queued_ids[i]) begin
      if (hit < 0 && queued_ids[i] == id) hit = i;
    end
    case (cmd)
      CMD_PUSH: begin
        if (queued_ids.size() < QUEUE_DEPTH) begin
          queued_ids.push_back(id);
          res.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      CMD_POP: begin
        if (queued_ids.size() != 0) begin
          res.out_id = queued_ids.pop_front();
          res.ok     = 1'b1;
        end
      end
      CMD_FIND: begin
        if (hit >= 0) begin
          res.out_id = id;
          res.ok     = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          queued_ids.delete(hit);
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count     = COUNT_W'(queued_ids.size());
    res.empty_res = (queued_ids.size() == 0);
    cmd_total[cmd]++;
    if (res.ok) cmd_ok[cmd]++;
    if (queued_ids.size() > peak_count) peak_count = queued_ids.size();
    return res;
  endfunction

  function automatic void add_cmd(cmd_e cmd, logic [ID_W-1:0] id, bit wait_drain);
    task_cmd_t item;
    item.cmd        = cmd;
    item.id         = id;
    item.wait_drain = wait_drain;
    pending_cmds.push_back(item);
  endfunction

  // small id set so that find and remove hit often, with full-range ids mixed in
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 8) return id_pool[r];
    if (r < 14) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_queue_result(offered.cmd, offered.id));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 14) &&
            (!pending_cmds[0].wait_drain || expected_results.size() == 0)) begin
          offered = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(IN_W - ID_W - 2){1'b0}}, offered.id, offered.cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side ready, with one long holdoff so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready     <= 1'b0;
      holdoff_left <= 0;
    end else if (cycle_cnt == HOLDOFF_AT) begin
      m_tready     <= 1'b0;
      holdoff_left <= HOLDOFF_LEN;
    end else if (holdoff_left != 0) begin
      m_tready     <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      m_tready <= quiet_window || ($urandom_range(0, 99) >= 14);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    queue_result_t got;
    queue_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.ok        = m_tdata[0];
      got.out_id    = m_tdata[16:1];
      got.count     = m_tdata[21:17];
      got.empty_res = m_tdata[22];
      checked_cnt++;
      if (expected_results.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected transaction ok=%0b out_id=%h count=%0d empty=%0b",
                 $time, got.ok, got.out_id, got.count, got.empty_res);
      end else begin
        want = expected_results.pop_front();
        if (got.ok !== want.ok || got.out_id !== want.out_id ||
            got.count !== want.count || got.empty_res !== want.empty_res) begin
          fail_cnt++;
          $display("%0t: mismatch expected ok=%0b out_id=%h count=%0d empty=%0b",
                   $time, want.ok, want.out_id, want.count, want.empty_res);
          $display("%0t:          actual   ok=%0b out_id=%h count=%0d empty=%0b",
                   $time, got.ok, got.out_id, got.count, got.empty_res);
        end
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned kind;
    int unsigned seg_len;
    int unsigned seg_idx;
    int unsigned made;
    cmd_e        cmd;

    // empty queue, extreme ids, duplicates, remove at head, middle and tail
    add_cmd(CMD_POP,    16'h1234, 1'b0);
    add_cmd(CMD_FIND,   16'h0000, 1'b0);
    add_cmd(CMD_REMOVE, 16'hFFFF, 1'b0);
    add_cmd(CMD_PUSH,   16'hFFFF, 1'b0);
    add_cmd(CMD_PUSH,   16'h0000, 1'b0);
    add_cmd(CMD_PUSH,   16'hFFFF, 1'b0);
    add_cmd(CMD_FIND,   16'hFFFF, 1'b0);
    add_cmd(CMD_FIND,   16'h1234, 1'b0);
    add_cmd(CMD_REMOVE, 16'hFFFF, 1'b0);
    add_cmd(CMD_REMOVE, 16'h5555, 1'b0);
    add_cmd(CMD_PUSH,   16'h8001, 1'b0);
    add_cmd(CMD_REMOVE, 16'h8001, 1'b0);
    add_cmd(CMD_POP,    16'hFFFF, 1'b0);
    add_cmd(CMD_POP,    16'h0000, 1'b0);
    add_cmd(CMD_POP,    16'hAAAA, 1'b0);
    add_cmd(CMD_PUSH,   16'hA5A5, 1'b0);
    add_cmd(CMD_PUSH,   16'h5A5A, 1'b0);
    add_cmd(CMD_PUSH,   16'h00FF, 1'b0);
    add_cmd(CMD_REMOVE, 16'h5A5A, 1'b0);
    add_cmd(CMD_FIND,   16'h00FF, 1'b0);
    add_cmd(CMD_POP,    16'h0000, 1'b0);
    add_cmd(CMD_POP,    16'h0000, 1'b0);

    // random segments biased to fill, drain or search, with some noise
    made    = 0;
    seg_idx = 0;
    while (made < RANDOM_CMDS) begin
      kind    = (seg_idx == 0) ? 0 : $urandom_range(0, 2);
      seg_len = $urandom_range(10, 60);
      for (int unsigned k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
          cmd = cmd_e'($urandom_range(0, 3));
        end else if (kind == 0) begin
          cmd = (r < 80) ? CMD_PUSH : (r < 88) ? CMD_POP : (r < 94) ? CMD_FIND : CMD_REMOVE;
        end else if (kind == 1) begin
          cmd = (r < 20) ? CMD_PUSH : (r < 75) ? CMD_POP : (r < 87) ? CMD_FIND : CMD_REMOVE;
        end else begin
          cmd = (r < 30) ? CMD_PUSH : (r < 40) ? CMD_POP : (r < 70) ? CMD_FIND : CMD_REMOVE;
        end
        add_cmd(cmd, pick_id(), (k == 0) && (seg_idx % 6 == 3));
        made++;
      end
      seg_idx++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    $display("covered: push %0d (%0d ok), pop %0d (%0d ok), find %0d (%0d hit), remove %0d (%0d hit)",
             cmd_total[CMD_PUSH], cmd_ok[CMD_PUSH], cmd_total[CMD_POP], cmd_ok[CMD_POP],
             cmd_total[CMD_FIND], cmd_ok[CMD_FIND], cmd_total[CMD_REMOVE], cmd_ok[CMD_REMOVE]);
    $display("covered: %0d results checked, %0d pushes refused when full, peak occupancy %0d",
             checked_cnt, full_refusals, peak_count);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout at %0t", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
sv/tiqr_pkg.sv
sv/tiqr_cell.sv
sv/task_id_queue_with_removal_core.sv
sv/tiqr_checker.sv
sim/tb_task_id_queue_with_removal_core.sv
